// ----- design/sti_pkg.sv -----
package sti_pkg;

    localparam int DEPTH_DEF        = 128;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam int KEY_W     = 32;
    localparam int PAY_IO_W  = 32;
    localparam int REQ_W     = 2;
    localparam int INDEX_W   = 7;
    localparam int COUNT_W   = 8;

    // request codes, code 3 is unused and answered as a no-op
    typedef logic [REQ_W-1:0] req_t;
    localparam req_t REQ_INSERT = 2'd0;
    localparam req_t REQ_LOOKUP = 2'd1;
    localparam req_t REQ_UPDATE = 2'd2;

    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2
    } status_t;

endpackage

// ----- design/sorted_table_insert_search_top.sv -----
// channel   | handshake               | payload
// ----------+-------------------------+---------------------------------------------
// request   | start, busy             | req_type, key, payload
// result    | done (one-cycle strobe) | status, index, payload_out, entry_count
//
// lookup and update run a binary search: one compare per cycle on the memory read
// data, up to floor(log2(entries))+1 compares.
// an insert walks down from the top entry, one shifted entry per cycle on the
// single memory write port.
// full, empty-table and unused-code requests answer the cycle after acceptance.
// rst_n clears the fill count and the sequencer, no memory clearing is needed.
// the result strobe cannot be stalled, a new item may start in the strobe cycle.
module sorted_table_insert_search_top #(
    parameter int DEPTH        = sti_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BITS = sti_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [sti_pkg::REQ_W-1:0]         req_type,
    input  logic signed [sti_pkg::KEY_W-1:0]  key,
    input  logic [sti_pkg::PAY_IO_W-1:0]      payload,
    output logic                              done,
    output logic [1:0]                        status,
    output logic [sti_pkg::INDEX_W-1:0]       index,
    output logic [sti_pkg::PAY_IO_W-1:0]      payload_out,
    output logic [sti_pkg::COUNT_W-1:0]       entry_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = sti_pkg::INDEX_W;
    localparam int OW = sti_pkg::PAY_IO_W;
    localparam int EW = sti_pkg::COUNT_W;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INS_CMP,
        ST_INS_LAST,
        ST_SRCH_CMP
    } state_t;

    state_t                     state_reg, state_next;
    logic [CW-1:0]              fill_reg, fill_next;
    logic signed [31:0]         key_reg, key_next;
    logic [PAYLOAD_BITS-1:0]    pay_reg, pay_next;
    sti_pkg::req_t              req_reg, req_next;
    logic [CW-1:0]              ptr_reg, ptr_next;
    logic [CW-1:0]              lo_reg, lo_next;
    logic [CW-1:0]              hi_reg, hi_next;
    logic [AW-1:0]              mid_reg, mid_next;
    logic                       done_reg, done_next;
    sti_pkg::status_t           status_reg, status_next;
    logic [AW-1:0]              index_reg, index_next;
    logic [PAYLOAD_BITS-1:0]    pout_reg, pout_next;

    logic signed [31:0]         key_mem [DEPTH];
    logic [PAYLOAD_BITS-1:0]    pay_mem [DEPTH];
    logic signed [31:0]         rd_key_reg;
    logic [PAYLOAD_BITS-1:0]    rd_pay_reg;

    logic                       mem_we;
    logic [AW-1:0]              mem_wa;
    logic signed [31:0]         mem_wkey;
    logic [PAYLOAD_BITS-1:0]    mem_wpay;
    logic [AW-1:0]              mem_ra;

    logic [PAYLOAD_BITS-1:0]    pay_in;
    logic [CW-1:0]              fill_m1;
    logic [CW-1:0]              ptr_m1;
    logic [CW-1:0]              ptr_m2;
    logic                       key_eq;
    logic                       key_lt;
    logic [CW-1:0]              lo_step;
    logic [CW-1:0]              hi_step;
    logic [CW-1:0]              lo_sel;
    logic [CW-1:0]              hi_sel;
    logic [CW:0]                mid_sum;
    logic [AW-1:0]              mid_new;

    assign pay_in  = PAYLOAD_BITS'(payload);
    assign fill_m1 = fill_reg - 1'b1;
    assign ptr_m1  = ptr_reg - 1'b1;
    assign ptr_m2  = ptr_reg - CW'(2);

    // search compare unit on the registered read data, used by lookup and update
    assign key_eq = (rd_key_reg == key_reg);
    assign key_lt = (rd_key_reg < key_reg);

    // hi is kept exclusive, mid = floor((lo + hi - 1) / 2)
    assign lo_step = key_lt ? (CW'(mid_reg) + 1'b1) : lo_reg;
    assign hi_step = key_lt ? hi_reg : CW'(mid_reg);
    assign lo_sel  = (state_reg == ST_IDLE) ? '0 : lo_step;
    assign hi_sel  = (state_reg == ST_IDLE) ? fill_reg : hi_step;
    assign mid_sum = (CW+1)'(lo_sel) + (CW+1)'(hi_sel) - 1'b1;
    assign mid_new = mid_sum[AW:1];

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        key_next    = key_reg;
        pay_next    = pay_reg;
        req_next    = req_reg;
        ptr_next    = ptr_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        index_next  = index_reg;
        pout_next   = pout_reg;
        mem_we      = 1'b0;
        mem_wa      = ptr_reg[AW-1:0];
        mem_wkey    = key_reg;
        mem_wpay    = pay_reg;
        mem_ra      = mid_new;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    key_next = key;
                    pay_next = pay_in;
                    req_next = req_type;
                    unique case (req_type) inside
                        sti_pkg::REQ_INSERT:
                        begin
                            if (fill_reg == FULL_COUNT)
                            begin
                                done_next   = 1'b1;
                                status_next = sti_pkg::STATUS_FULL;
                                index_next  = '0;
                                pout_next   = '0;
                            end
                            else if (fill_reg == '0)
                            begin
                                mem_we      = 1'b1;
                                mem_wa      = '0;
                                mem_wkey    = key;
                                mem_wpay    = pay_in;
                                fill_next   = fill_reg + 1'b1;
                                done_next   = 1'b1;
                                status_next = sti_pkg::STATUS_DONE;
                                index_next  = '0;
                                pout_next   = '0;
                            end
                            else
                            begin
                                ptr_next   = fill_reg;
                                mem_ra     = fill_m1[AW-1:0];
                                state_next = ST_INS_CMP;
                            end
                        end
                        sti_pkg::REQ_LOOKUP, sti_pkg::REQ_UPDATE:
                        begin
                            if (fill_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = sti_pkg::STATUS_NOT_FOUND;
                                index_next  = '0;
                                pout_next   = '0;
                            end
                            else
                            begin
                                lo_next    = '0;
                                hi_next    = fill_reg;
                                mid_next   = mid_new;
                                state_next = ST_SRCH_CMP;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = sti_pkg::STATUS_DONE;
                            index_next  = '0;
                            pout_next   = '0;
                        end
                    endcase
                end
            end

            ST_INS_CMP:
            begin
                if (rd_key_reg > key_reg)
                begin
                    // move the larger entry up one slot, fetch the next one down
                    mem_we   = 1'b1;
                    mem_wkey = rd_key_reg;
                    mem_wpay = rd_pay_reg;
                    ptr_next = ptr_m1;
                    mem_ra   = ptr_m2[AW-1:0];
                    if (ptr_m1 == '0)
                    begin
                        state_next = ST_INS_LAST;
                    end
                end
                else
                begin
                    mem_we      = 1'b1;
                    fill_next   = fill_reg + 1'b1;
                    done_next   = 1'b1;
                    status_next = sti_pkg::STATUS_DONE;
                    index_next  = ptr_reg[AW-1:0];
                    pout_next   = '0;
                    state_next  = ST_IDLE;
                end
            end

            ST_INS_LAST:
            begin
                mem_we      = 1'b1;
                mem_wa      = '0;
                fill_next   = fill_reg + 1'b1;
                done_next   = 1'b1;
                status_next = sti_pkg::STATUS_DONE;
                index_next  = '0;
                pout_next   = '0;
                state_next  = ST_IDLE;
            end

            ST_SRCH_CMP:
            begin
                if (key_eq)
                begin
                    done_next   = 1'b1;
                    status_next = sti_pkg::STATUS_DONE;
                    index_next  = mid_reg;
                    pout_next   = '0;
                    state_next  = ST_IDLE;
                    if (req_reg == sti_pkg::REQ_LOOKUP)
                    begin
                        pout_next = rd_pay_reg;
                    end
                    else
                    begin
                        mem_we   = 1'b1;
                        mem_wa   = mid_reg;
                        mem_wkey = rd_key_reg;
                        mem_wpay = pay_reg;
                    end
                end
                else
                begin
                    lo_next = lo_step;
                    hi_next = hi_step;
                    if (lo_step < hi_step)
                    begin
                        mid_next = mid_new;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        status_next = sti_pkg::STATUS_NOT_FOUND;
                        index_next  = '0;
                        pout_next   = '0;
                        state_next  = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            key_reg    <= '0;
            pay_reg    <= '0;
            req_reg    <= sti_pkg::REQ_INSERT;
            ptr_reg    <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            mid_reg    <= '0;
            done_reg   <= 1'b0;
            status_reg <= sti_pkg::STATUS_DONE;
            index_reg  <= '0;
            pout_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            key_reg    <= key_next;
            pay_reg    <= pay_next;
            req_reg    <= req_next;
            ptr_reg    <= ptr_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            mid_reg    <= mid_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            index_reg  <= index_next;
            pout_reg   <= pout_next;
        end
    end

    // table storage: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[mem_wa] <= mem_wkey;
            pay_mem[mem_wa] <= mem_wpay;
        end
        rd_key_reg <= key_mem[mem_ra];
        rd_pay_reg <= pay_mem[mem_ra];
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign index       = IW'(index_reg);
    assign payload_out = OW'(pout_reg);
    assign entry_count = EW'(fill_reg);

endmodule

// ----- design/sti_checker.sv -----
module sti_checker #(
    parameter int DEPTH = sti_pkg::DEPTH_DEF
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              done,
    input logic [1:0]                        status,
    input logic [sti_pkg::INDEX_W-1:0]       index,
    input logic [sti_pkg::PAY_IO_W-1:0]      payload_out,
    input logic [sti_pkg::COUNT_W-1:0]       entry_count
);

    localparam logic [sti_pkg::COUNT_W-1:0] FULL_SEEN = sti_pkg::COUNT_W'(DEPTH);

    // an accepted item either keeps the block busy or answers right away
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted item neither started work nor answered");

    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == sti_pkg::STATUS_FULL)) |-> (entry_count == FULL_SEEN))
        else $error("full status with table not full");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != sti_pkg::STATUS_DONE)) |-> ((index == '0) && (payload_out == '0)))
        else $error("failed request reports nonzero index or payload");

endmodule

bind sorted_table_insert_search_top sti_checker #(.DEPTH(DEPTH)) u_sti_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .index       (index),
    .payload_out (payload_out),
    .entry_count (entry_count)
);

// ----- test/sorted_table_insert_search_top_test.sv -----
`timescale 1ns / 1ps

module sorted_table_insert_search_top_test;

    localparam int            DEPTH      = sti_pkg::DEPTH_DEF;
    localparam sti_pkg::req_t REQ_UNUSED = 2'd3;

    typedef struct {
        sti_pkg::status_t status;
        logic [6:0]       index;
        logic [31:0]      payload_out;
        logic [7:0]       entry_count;
    } answer_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  req_type;
    logic signed [31:0] key;
    logic [31:0] payload;
    logic        done;
    logic [1:0]  status;
    logic [6:0]  index;
    logic [31:0] payload_out;
    logic [7:0]  entry_count;

    // mirror of the sorted table
    logic signed [31:0] table_keys [DEPTH];
    logic [31:0]        table_pays [DEPTH];
    int                 table_fill;

    answer_t answers_due[$];

    int errors      = 0;
    int n_inserted  = 0;
    int n_refused   = 0;
    int n_hits      = 0;
    int n_misses    = 0;
    int n_ignored   = 0;

    sorted_table_insert_search_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .key         (key),
        .payload     (payload),
        .done        (done),
        .status      (status),
        .index       (index),
        .payload_out (payload_out),
        .entry_count (entry_count)
    );

    always #6 clk = ~clk;

    // binary search with the exact midpoint sequence, first probe hit wins
    function automatic bit find_key(input logic signed [31:0] k, output int pos);
        int lo;
        int hi;
        int mid;
        lo  = 0;
        hi  = table_fill - 1;
        pos = 0;
        while (lo <= hi)
        begin
            mid = (lo + hi) / 2;
            if (table_keys[mid] == k)
            begin
                pos = mid;
                return 1'b1;
            end
            else if (table_keys[mid] < k)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return 1'b0;
    endfunction

    function automatic answer_t apply_request(sti_pkg::req_t rt, logic signed [31:0] k,
                                              logic [31:0] p);
        answer_t a;
        int      pos;
        a.status      = sti_pkg::STATUS_DONE;
        a.index       = '0;
        a.payload_out = '0;
        case (rt)
            sti_pkg::REQ_INSERT:
            begin
                if (table_fill >= DEPTH)
                begin
                    a.status = sti_pkg::STATUS_FULL;
                    n_refused++;
                end
                else
                begin
                    // equal keys stay in arrival order
                    pos = table_fill;
                    while (pos > 0 && table_keys[pos-1] > k)
                    begin
                        table_keys[pos] = table_keys[pos-1];
                        table_pays[pos] = table_pays[pos-1];
                        pos--;
                    end
                    table_keys[pos] = k;
                    table_pays[pos] = p;
                    table_fill++;
                    a.index = 7'(pos);
                    n_inserted++;
                end
            end
            sti_pkg::REQ_LOOKUP:
            begin
                if (find_key(k, pos))
                begin
                    a.index       = 7'(pos);
                    a.payload_out = table_pays[pos];
                    n_hits++;
                end
                else
                begin
                    a.status = sti_pkg::STATUS_NOT_FOUND;
                    n_misses++;
                end
            end
            sti_pkg::REQ_UPDATE:
            begin
                if (find_key(k, pos))
                begin
                    a.index         = 7'(pos);
                    table_pays[pos] = p;
                    n_hits++;
                end
                else
                begin
                    a.status = sti_pkg::STATUS_NOT_FOUND;
                    n_misses++;
                end
            end
            default:
                n_ignored++;
        endcase
        a.entry_count = 8'(table_fill);
        return a;
    endfunction

    task automatic send_item(sti_pkg::req_t rt, logic signed [31:0] k, logic [31:0] p);
        @(negedge clk);
        start    <= 1'b1;
        req_type <= rt;
        key      <= k;
        payload  <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        answers_due.push_back(apply_request(rt, k, p));
    endtask

    task automatic idle_gap(int pct);
        while ($urandom_range(99) < pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic wait_all_answered();
        @(negedge clk);
        start <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_key();
        int v;
        case ($urandom_range(9))
            0, 1, 2, 3:
            begin
                // narrow range to get plenty of equal keys
                v = $urandom_range(16);
                return v - 8;
            end
            4, 5:
            begin
                if (table_fill > 0)
                    return table_keys[$urandom_range(table_fill - 1)];
                return $urandom;
            end
            6:
            begin
                case ($urandom_range(3))
                    0:       return 32'sh7fffffff;
                    1:       return 32'sh80000000;
                    2:       return -1;
                    default: return 0;
                endcase
            end
            default:
                return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_payload();
        case ($urandom_range(9))
            0:       return 32'h0;
            1:       return 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_table();
        send_item(sti_pkg::REQ_LOOKUP, 0, 32'h12345678);
        send_item(sti_pkg::REQ_UPDATE, -1, 32'hffffffff);
        send_item(REQ_UNUSED, 32'sh7fffffff, 32'hffffffff);
    endtask

    task automatic test_extremes_and_duplicates();
        send_item(sti_pkg::REQ_INSERT, 0, 32'h00000000);
        send_item(sti_pkg::REQ_INSERT, 32'sh7fffffff, 32'hffffffff);
        send_item(sti_pkg::REQ_INSERT, 32'sh80000000, 32'ha5a5a5a5);
        send_item(sti_pkg::REQ_INSERT, 0, 32'h00000001);
        send_item(sti_pkg::REQ_INSERT, 0, 32'h00000002);
        send_item(sti_pkg::REQ_INSERT, -1, 32'h5a5a5a5a);
        send_item(sti_pkg::REQ_LOOKUP, 0, 32'h0);
        send_item(sti_pkg::REQ_LOOKUP, 32'sh7fffffff, 32'h0);
        send_item(sti_pkg::REQ_LOOKUP, 32'sh80000000, 32'h0);
        send_item(sti_pkg::REQ_LOOKUP, -1, 32'h0);
        send_item(sti_pkg::REQ_LOOKUP, 12345, 32'h0);
        send_item(sti_pkg::REQ_UPDATE, 0, 32'hdeadbeef);
        send_item(sti_pkg::REQ_LOOKUP, 0, 32'h0);
        send_item(sti_pkg::REQ_UPDATE, 32'sh7ffffffe, 32'h11111111);
        send_item(sti_pkg::REQ_UPDATE, 32'sh80000000, 32'hffffffff);
        send_item(sti_pkg::REQ_LOOKUP, 32'sh80000000, 32'h0);
        send_item(REQ_UNUSED, 32'sh80000000, 32'h0);
        send_item(sti_pkg::REQ_INSERT, 1, 32'h80000000);
        send_item(sti_pkg::REQ_LOOKUP, 1, 32'h7fffffff);
    endtask

    // mostly searches for stored keys, inserts at insert_pct, refused once the table is full
    task automatic test_random_traffic(int idle_pct, int n_items, int insert_pct);
        int                 sent;
        int                 r;
        sti_pkg::req_t      rt;
        logic signed [31:0] k;
        sent = 0;
        while (sent < n_items)
        begin
            idle_gap(idle_pct);
            if ($urandom_range(49) == 0)
                wait_all_answered();
            r = $urandom_range(99);
            if (r < 3)
                rt = REQ_UNUSED;
            else if (r < 3 + insert_pct)
                rt = sti_pkg::REQ_INSERT;
            else if ($urandom_range(2) != 0)
                rt = sti_pkg::REQ_LOOKUP;
            else
                rt = sti_pkg::REQ_UPDATE;
            if (rt != sti_pkg::REQ_INSERT && table_fill > 0 && $urandom_range(9) < 7)
                k = table_keys[$urandom_range(table_fill - 1)];
            else
                k = pick_key();
            send_item(rt, k, pick_payload());
            if (rt != REQ_UNUSED)
                sent++;
        end
    endtask

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && done)
        begin
            if (answers_due.size() == 0)
            begin
                $error("result with no request pending: status %0d index %0d",
                       status, index);
                errors++;
            end
            else
            begin
                want = answers_due.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    errors++;
                end
                if (index !== want.index)
                begin
                    $error("index: expected %0d, got %0d", want.index, index);
                    errors++;
                end
                if (payload_out !== want.payload_out)
                begin
                    $error("payload_out: expected %h, got %h", want.payload_out, payload_out);
                    errors++;
                end
                if (entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d", want.entry_count, entry_count);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d results outstanding", answers_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        req_type   = '0;
        key        = '0;
        payload    = '0;
        table_fill = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_extremes_and_duplicates();
        wait_all_answered();
        test_random_traffic(31, 475, 12);
        wait_all_answered();
        test_random_traffic(85, 475, 12);
        wait_all_answered();
        test_random_traffic(0, 475, 30);
        wait_all_answered();

        // an insert into a nearly full table shifts up to DEPTH - 1 entries
        repeat (DEPTH + 40) @(posedge clk);
        if (answers_due.size() != 0)
        begin
            $error("%0d results never arrived", answers_due.size());
            errors++;
        end

        $display("covered %0d inserts, %0d refused on a full table, %0d keys found, %0d missed",
                 n_inserted, n_refused, n_hits, n_misses);
        $display("plus %0d unused request codes, final fill %0d of %0d",
                 n_ignored, table_fill, DEPTH);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
design/sti_pkg.sv
design/sorted_table_insert_search_top.sv
design/sti_checker.sv
test/sorted_table_insert_search_top_test.sv
